FILE: rtl/kip_pkg.sv
// Package for the inverse-pair count core: sizes, modulus, state codes
// and the modular add and subtract helpers. No dependencies.
package kip_pkg;

  localparam int MAX_N  = 1024;
  localparam int MAX_K  = 1024;
  localparam int LEN_W  = 11;
  localparam int DEPTH  = MAX_K + 1;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int VAL_W  = 30;

  localparam logic [VAL_W-1:0] PRIME       = 30'd1000000007;
  localparam logic [VAL_W-1:0] RANGE_ERROR = 30'h3FFFFFFF;

  typedef logic [VAL_W-1:0]  val_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INIT,
    ST_ROW,
    ST_DRAIN,
    ST_FETCH,
    ST_RESULT
  } state_e;

  function automatic val_t mod_add(val_t x, val_t y);
    logic [VAL_W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, PRIME}) begin
      s = s - {1'b0, PRIME};
    end
    return s[VAL_W-1:0];
  endfunction

  function automatic val_t mod_sub(val_t x, val_t y);
    logic [VAL_W:0] s;
    if (x >= y) begin
      s = {1'b0, x} - {1'b0, y};
    end else begin
      s = {1'b0, x} + {1'b0, PRIME} - {1'b0, y};
    end
    return s[VAL_W-1:0];
  endfunction

endpackage

FILE: rtl/k_inverse_pairs_count_core.sv
// Top level of the inverse-pair count core: sequencer, window-sum datapath
// and two ping-pong row stores. Depends on kip_pkg and kip_row_ram.
//
//   channel | direction | handshake           | payload
//   --------+-----------+---------------------+-------------------------------
//   request | in        | in_valid_i/stall_o  | perm_length_i, inversions_i
//   result  | out       | out_valid_o/stall_i | count_mod_o
//
// A request runs one store read-modify-write per table entry plus a drain per row.
// An out-of-range request goes straight to the result state without touching the stores.
// Reset clears the control state; row stores are not cleared.
// A new request is taken while an earlier result still waits under stall.
module k_inverse_pairs_count_core
  import kip_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [LEN_W-1:0] perm_length_i,
  input  logic [LEN_W-1:0] inversions_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [VAL_W-1:0] count_mod_o
);

  state_e state_q, state_d;

  logic [LEN_W-1:0] n_q;
  logic [LEN_W-1:0] i_q;
  addr_t            k_q;
  addr_t            j_q;
  logic             sel_q;
  logic             err_q;
  val_t             ws_q;
  logic             p1_v_q, p1_sub_q, p2_v_q;
  addr_t            p1_j_q, p2_j_q;
  val_t             diff_q, diff_d;
  logic             out_valid_q;
  val_t             out_q;

  logic  accept;
  logic  out_load;
  logic  issue;
  logic  sub_now;
  logic  row_last;
  logic  drained;
  addr_t raddr0, raddr1;
  val_t  a0, a1, b0, b1;
  val_t  src0, src1;
  val_t  ws_new;
  logic  we_a, we_b;
  addr_t waddr_a, waddr_b;
  val_t  wdata_a;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign issue      = (state_q == ST_ROW);
  assign sub_now    = (LEN_W'(j_q) >= i_q);
  assign row_last   = (j_q == k_q);
  assign drained    = !p1_v_q && !p2_v_q;
  assign out_load   = (state_q == ST_RESULT) && (!out_valid_q || !out_stall_i);

  assign raddr0 = issue ? j_q : k_q;
  assign raddr1 = ADDR_W'(LEN_W'(j_q) - i_q);

  assign src0   = sel_q ? b0 : a0;
  assign src1   = sel_q ? b1 : a1;
  assign diff_d = mod_sub(src0, p1_sub_q ? src1 : '0);
  assign ws_new = mod_add(ws_q, diff_q);

  always_comb begin
    we_a    = 1'b0;
    we_b    = 1'b0;
    waddr_a = p2_j_q;
    waddr_b = p2_j_q;
    wdata_a = ws_new;
    if (state_q == ST_INIT) begin
      we_a    = 1'b1;
      waddr_a = j_q;
      wdata_a = (j_q == '0) ? val_t'(1) : '0;
    end else if (p2_v_q) begin
      we_a = sel_q;
      we_b = !sel_q;
    end
  end

  kip_row_ram u_row_a (
    .clk_i    (clk_i),
    .we_i     (we_a),
    .waddr_i  (waddr_a),
    .wdata_i  (wdata_a),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (a0),
    .rdata1_o (a1)
  );

  kip_row_ram u_row_b (
    .clk_i    (clk_i),
    .we_i     (we_b),
    .waddr_i  (waddr_b),
    .wdata_i  (ws_new),
    .raddr0_i (raddr0),
    .raddr1_i (raddr1),
    .rdata0_o (b0),
    .rdata1_o (b1)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (perm_length_i > LEN_W'(MAX_N) || inversions_i > LEN_W'(MAX_K)) begin
            state_d = ST_RESULT;
          end else begin
            state_d = ST_INIT;
          end
        end
      end
      ST_INIT: begin
        if (row_last) begin
          state_d = (n_q == '0) ? ST_FETCH : ST_ROW;
        end
      end
      ST_ROW: begin
        if (row_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (drained) begin
          state_d = (i_q == n_q) ? ST_FETCH : ST_ROW;
        end
      end
      ST_FETCH:  state_d = ST_RESULT;
      ST_RESULT: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= '0;
      i_q    <= '0;
      k_q    <= '0;
      j_q    <= '0;
      sel_q  <= 1'b0;
      err_q  <= 1'b0;
      ws_q   <= '0;
      p1_v_q <= 1'b0;
      p2_v_q <= 1'b0;
    end else begin
      p1_v_q <= issue;
      p2_v_q <= p1_v_q;
      if (p2_v_q) begin
        ws_q <= ws_new;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            n_q   <= perm_length_i;
            k_q   <= ADDR_W'(inversions_i);
            j_q   <= '0;
            sel_q <= 1'b0;
            err_q <= (perm_length_i > LEN_W'(MAX_N)) || (inversions_i > LEN_W'(MAX_K));
          end
        end
        ST_INIT: begin
          if (row_last) begin
            j_q  <= '0;
            i_q  <= LEN_W'(1);
            ws_q <= '0;
          end else begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_ROW: begin
          if (!row_last) begin
            j_q <= j_q + 1'b1;
          end
        end
        ST_DRAIN: begin
          if (drained) begin
            sel_q <= !sel_q;
            i_q   <= i_q + 1'b1;
            j_q   <= '0;
            ws_q  <= '0;
          end
        end
        ST_FETCH, ST_RESULT: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    p1_j_q   <= j_q;
    p1_sub_q <= sub_now;
    p2_j_q   <= p1_j_q;
    diff_q   <= diff_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= err_q ? RANGE_ERROR : src0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign count_mod_o = out_q;

endmodule

FILE: rtl/kip_row_ram.sv
// One row store: one write port, two registered read ports.
// Depends on kip_pkg for depth and word width.
module kip_row_ram
  import kip_pkg::*;
(
  input  logic  clk_i,
  input  logic  we_i,
  input  addr_t waddr_i,
  input  val_t  wdata_i,
  input  addr_t raddr0_i,
  input  addr_t raddr1_i,
  output val_t  rdata0_o,
  output val_t  rdata1_o
);

  val_t mem [DEPTH];
  val_t rdata0_q;
  val_t rdata1_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata0_q <= mem[raddr0_i];
    rdata1_q <= mem[raddr1_i];
  end

  assign rdata0_o = rdata0_q;
  assign rdata1_o = rdata1_q;

endmodule

FILE: bench/k_inverse_pairs_count_core_test.sv
// Self-checking bench for k_inverse_pairs_count_core: directed and random requests,
// checked against a built-in table predictor. Stalls and gaps on both channels.
// Depends on kip_pkg and the core RTL only.
module k_inverse_pairs_count_core_test;
  import kip_pkg::*;

  class count_scoreboard;
    val_t             expected_counts[$];
    int unsigned      errors;
    val_t             row_x[DEPTH];
    val_t             row_y[DEPTH];
    val_t             run_sum;

    function new();
      errors   = 0;
      run_sum  = '0;
    endfunction

    function val_t add_mod(val_t x, val_t y);
      longint unsigned s;
      s = x;
      s += y;
      if (s >= PRIME) begin
        s -= PRIME;
      end
      return val_t'(s);
    endfunction

    function val_t sub_mod(val_t x, val_t y);
      longint unsigned s;
      s = x;
      s += PRIME;
      s -= y;
      if (s >= PRIME) begin
        s -= PRIME;
      end
      return val_t'(s);
    endfunction

    function val_t mahonian_count(logic [LEN_W-1:0] n, logic [LEN_W-1:0] k);
      int i;
      int j;
      bit from_x;
      if (n > MAX_N || k > MAX_K) begin
        return RANGE_ERROR;
      end
      row_x[0] = 1;
      for (j = 1; j <= k; j++) begin
        row_x[j] = '0;
      end
      from_x = 1'b1;
      for (i = 1; i <= n; i++) begin
        run_sum = 1;
        if (from_x) begin
          row_y[0] = 1;
        end else begin
          row_x[0] = 1;
        end
        for (j = 1; j <= k; j++) begin
          run_sum = add_mod(run_sum, from_x ? row_x[j] : row_y[j]);
          if (j >= i) begin
            run_sum = sub_mod(run_sum, from_x ? row_x[j-i] : row_y[j-i]);
          end
          if (from_x) begin
            row_y[j] = run_sum;
          end else begin
            row_x[j] = run_sum;
          end
        end
        from_x = !from_x;
      end
      return from_x ? row_x[k] : row_y[k];
    endfunction

    function void note_request(logic [LEN_W-1:0] n, logic [LEN_W-1:0] k);
      expected_counts.push_back(mahonian_count(n, k));
    endfunction

    function void check_count(val_t got);
      val_t want;
      if (expected_counts.size() == 0) begin
        $error("count_mod: expected none, got %0d", got);
        errors++;
      end else begin
        want = expected_counts.pop_front();
        if (got !== want) begin
          $error("count_mod: expected %0d, got %0d", want, got);
          errors++;
        end
      end
    endfunction
  endclass

  logic             clk_i;
  logic             rst_ni;
  logic             in_valid_i;
  logic             in_stall_o;
  logic [LEN_W-1:0] perm_length_i;
  logic [LEN_W-1:0] inversions_i;
  logic             out_valid_o;
  logic             out_stall_i;
  logic [VAL_W-1:0] count_mod_o;

  bit quiet     = 1'b0;
  bit long_hold = 1'b0;

  count_scoreboard board;

  k_inverse_pairs_count_core uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_stall_o    (in_stall_o),
    .perm_length_i (perm_length_i),
    .inversions_i  (inversions_i),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .count_mod_o   (count_mod_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #40_000_000;
    $display("k_inverse_pairs_count_core test failed");
    $finish;
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o) begin
        board.note_request(perm_length_i, inversions_i);
      end
      if (out_valid_o && !out_stall_i) begin
        board.check_count(count_mod_o);
      end
    end
  end

  initial begin : result_sink
    int unsigned hold;
    out_stall_i = 1'b1;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        hold      = 600;
        long_hold = 1'b0;
      end else begin
        hold = quiet ? 0 : $urandom_range(0, 19);
      end
      if (hold != 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!(out_valid_o && !out_stall_i));
    end
  end

  task automatic send_request(input logic [LEN_W-1:0] n, input logic [LEN_W-1:0] k);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 19);
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    perm_length_i <= n;
    inversions_i  <= k;
    in_valid_i    <= 1'b1;
    do @(posedge clk_i); while (!(in_valid_i && !in_stall_o));
  endtask

  // hold the input low until every pending count has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (board.expected_counts.size() != 0) @(posedge clk_i);
  endtask

  task automatic pick_request(output logic [LEN_W-1:0] n, output logic [LEN_W-1:0] k);
    int r;
    int m;
    int kk;
    r = $urandom_range(0, 99);
    if (r < 62) begin
      n = LEN_W'($urandom_range(0, 40));
      k = LEN_W'($urandom_range(0, 60));
    end else if (r < 70) begin
      m  = $urandom_range(1, 12);
      n  = LEN_W'(m);
      kk = m * (m - 1) / 2 + $urandom_range(0, 4) - 2;
      k  = (kk < 0) ? '0 : LEN_W'(kk);
    end else if (r < 79) begin
      n = LEN_W'($urandom_range(0, 120));
      k = LEN_W'($urandom_range(0, 80));
    end else if (r < 85) begin
      n = LEN_W'($urandom_range(200, MAX_N));
      k = LEN_W'($urandom_range(0, 8));
    end else if (r < 91) begin
      n = LEN_W'($urandom_range(0, 3));
      k = LEN_W'($urandom_range(200, MAX_K));
    end else begin
      n = LEN_W'($urandom_range(0, 2047));
      k = LEN_W'($urandom_range(0, 2047));
      if ($urandom_range(0, 1)) begin
        n = LEN_W'($urandom_range(MAX_N + 1, 2047));
      end else begin
        k = LEN_W'($urandom_range(MAX_K + 1, 2047));
      end
    end
  endtask

  initial begin : request_source
    logic [LEN_W-1:0] n;
    logic [LEN_W-1:0] k;
    int               idx;
    board         = new();
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    perm_length_i = '0;
    inversions_i  = '0;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_request(0, 0);       send_request(0, 1);       send_request(0, 1024);
    send_request(1, 0);       send_request(1, 1);       send_request(2, 1);
    send_request(2, 2);       send_request(3, 3);       send_request(3, 4);
    send_request(4, 6);       send_request(4, 7);       send_request(5, 10);
    send_request(10, 20);     send_request(13, 40);     send_request(1024, 0);
    send_request(1024, 3);    send_request(7, 1024);    send_request(1025, 0);
    send_request(0, 1025);    send_request(1025, 1025); send_request(2047, 2047);
    send_request(1024, 1025); send_request(1365, 682);  send_request(682, 1365);
    drain();

    quiet = 1'b1;
    for (idx = 0; idx < 10; idx++) begin
      send_request(LEN_W'($urandom_range(0, 20)), LEN_W'($urandom_range(0, 30)));
    end
    drain();

    long_hold = 1'b1;
    for (idx = 0; idx < 6; idx++) begin
      send_request(LEN_W'($urandom_range(0, 6)), LEN_W'($urandom_range(0, 10)));
    end
    drain();
    quiet = 1'b0;

    for (idx = 0; idx < 60; idx++) begin
      pick_request(n, k);
      send_request(n, k);
      if (idx % 20 == 19) begin
        drain();
      end
    end
    drain();
    repeat (50) @(posedge clk_i);

    if (board.errors == 0 && board.expected_counts.size() == 0) begin
      $display("k_inverse_pairs_count_core test passed");
    end else begin
      $display("k_inverse_pairs_count_core test failed");
    end
    $finish;
  end

endmodule

FILE: k_inverse_pairs_count_core.f
rtl/kip_pkg.sv
rtl/kip_row_ram.sv
rtl/k_inverse_pairs_count_core.sv
bench/k_inverse_pairs_count_core_test.sv
